// File: sv/smalu_pkg.sv
// smalu_pkg: shared types, op and error codes for the stack machine alu
// no dependencies
`default_nettype none
package smalu_pkg;
	localparam int STACK_DEPTH_DEF = 16;

	typedef enum logic [3:0] {
		OP_PUSH = 4'd0, OP_ADD = 4'd1, OP_SUB = 4'd2, OP_MUL = 4'd3,
		OP_DIV = 4'd4, OP_MOD = 4'd5, OP_INC = 4'd6, OP_DEC = 4'd7,
		OP_NEG = 4'd8, OP_ABS = 4'd9, OP_POW = 4'd10, OP_SQRT = 4'd11,
		OP_MIN = 4'd12, OP_MAX = 4'd13, OP_AVG = 4'd14, OP_NOP = 4'd15
	} op_t;

	typedef enum logic [2:0] {
		ERR_OK = 3'd0, ERR_UNDER = 3'd1, ERR_OVER = 3'd2,
		ERR_DIVZ = 3'd3, ERR_NSQRT = 3'd4
	} err_t;

	typedef struct packed {
		logic [3:0]         op;
		logic signed [31:0] push_value;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] top_value;
		logic [4:0]         depth;
		logic [2:0]         error;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RD, ST_EXEC, ST_ITER, ST_WB
	} state_t;
endpackage
`default_nettype wire

// File: sv/smalu_front.sv
// smalu_front: accepts commands into a two-entry queue
// depends on smalu_pkg
`default_nettype none
module smalu_front import smalu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire cmd_t cmd,
	output logic      busy,
	output logic      q_valid,
	output cmd_t      q_cmd,
	input  wire logic q_pop
);
	cmd_t       ent_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign busy    = (cnt_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd   = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (q_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule
`default_nettype wire

// File: sv/smalu_back.sv
// smalu_back: stack memory, alu and iterative div/sqrt/pow unit
// depends on smalu_pkg
`default_nettype none
module smalu_back import smalu_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	input  wire cmd_t q_cmd,
	output logic      q_pop,
	output logic      done,
	output res_t      res
);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [31:0] mem [STACK_DEPTH];
	logic [31:0] rda_q, rdb_q;
	logic [CW-1:0] cnt_q;
	state_t st_q, st_d;
	cmd_t   c_q;
	logic [2:0]  err_q;
	logic [31:0] r_q;
	logic [1:0]  need;
	logic        wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_data;
	logic [CW-1:0] new_cnt;
	// iterative unit
	logic [5:0]  it_q;
	logic [31:0] quo_q, rem_q, dvs_q, acc_q, base_q, exp_q, bit_q;
	logic        na_q, nb_q;

	always_comb begin
		unique case (op_t'(c_q.op))
			OP_INC, OP_DEC, OP_NEG, OP_ABS, OP_SQRT: need = 2'd1;
			default:                                 need = 2'd2;
		endcase
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (q_valid) st_d = ST_RD;
			ST_RD:   st_d = ST_EXEC;
			ST_EXEC: begin
				if (err_q == ERR_OK && (c_q.op == OP_DIV || c_q.op == OP_MOD ||
				    c_q.op == OP_POW || c_q.op == OP_SQRT)) st_d = ST_ITER;
				else st_d = ST_WB;
			end
			ST_ITER: if (it_q == 6'd0) st_d = ST_WB;
			ST_WB:   st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	assign q_pop = (st_q == ST_IDLE) && q_valid;

	logic [CW-1:0] ia, ib;
	assign ib = cnt_q - CW'(1);
	assign ia = cnt_q - CW'(2);

	always_ff @(posedge clk) begin
		rdb_q <= mem[ib[AW-1:0]];
		rda_q <= mem[ia[AW-1:0]];
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	logic [32:0] rem_sh;
	logic [32:0] avg_s;
	logic [31:0] sq_t;

	always_comb begin
		wr_en = 1'b0; wr_addr = '0; wr_data = r_q; new_cnt = cnt_q;
		if (st_q == ST_WB && err_q == ERR_OK && c_q.op != OP_NOP) begin
			wr_en = 1'b1;
			if (c_q.op == OP_PUSH) begin
				wr_addr = cnt_q[AW-1:0]; wr_data = c_q.push_value;
				new_cnt = cnt_q + CW'(1);
			end else begin
				new_cnt = cnt_q - CW'(need) + CW'(1);
				wr_addr = AW'(cnt_q - CW'(need));
			end
		end
	end

	assign rem_sh = {rem_q, quo_q[31]};
	assign avg_s  = {rda_q[31], rda_q} + {rdb_q[31], rdb_q};
	assign sq_t   = acc_q | bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; cnt_q <= '0; done <= 1'b0;
		end else begin
			st_q <= st_d;
			done <= (st_q == ST_WB);
			cnt_q <= new_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) c_q <= q_cmd;
		unique case (st_q)
			ST_RD: begin
				if (c_q.op == OP_PUSH && cnt_q >= CW'(STACK_DEPTH))
					err_q <= ERR_OVER;
				else if (c_q.op != OP_PUSH && c_q.op != OP_NOP && cnt_q < CW'(need))
					err_q <= ERR_UNDER;
				else
					err_q <= ERR_OK;
			end
			ST_EXEC: begin
				it_q <= (c_q.op == OP_SQRT) ? 6'd16 : 6'd32;
				na_q <= rda_q[31]; nb_q <= rdb_q[31];
				quo_q <= (c_q.op == OP_SQRT) ? rdb_q : (rda_q[31] ? -rda_q : rda_q);
				rem_q <= '0;
				dvs_q <= rdb_q[31] ? -rdb_q : rdb_q;
				acc_q <= (c_q.op == OP_SQRT) ? 32'd0 : 32'd1;
				base_q <= rda_q;
				// negative exponent gives 1
				exp_q <= rdb_q[31] ? 32'd0 : rdb_q;
				bit_q <= 32'h4000_0000;
				if (err_q == ERR_OK) unique case (op_t'(c_q.op))
					OP_ADD: r_q <= rda_q + rdb_q;
					OP_SUB: r_q <= rda_q - rdb_q;
					OP_MUL: r_q <= rda_q * rdb_q;
					OP_DIV, OP_MOD: if (rdb_q == '0) err_q <= ERR_DIVZ;
					OP_INC: r_q <= rdb_q + 32'd1;
					OP_DEC: r_q <= rdb_q - 32'd1;
					OP_NEG: r_q <= -rdb_q;
					OP_ABS: r_q <= rdb_q[31] ? -rdb_q : rdb_q;
					OP_SQRT: if (rdb_q[31]) err_q <= ERR_NSQRT;
					OP_MIN: r_q <= ($signed(rda_q) < $signed(rdb_q)) ? rda_q : rdb_q;
					OP_MAX: r_q <= ($signed(rda_q) > $signed(rdb_q)) ? rda_q : rdb_q;
					// 33-bit sum, rounded toward zero before the halving
					OP_AVG: r_q <= 32'((avg_s + {32'd0, avg_s[32]}) >> 1);
					default: r_q <= r_q;
				endcase
			end
			ST_ITER: begin
				it_q <= it_q - 6'd1;
				if (c_q.op == OP_SQRT) begin
					if (it_q != 6'd0) begin
						if (quo_q >= sq_t) begin
							quo_q <= quo_q - sq_t; acc_q <= (acc_q >> 1) | bit_q;
						end else acc_q <= acc_q >> 1;
						bit_q <= bit_q >> 2;
					end else r_q <= acc_q;
				end else if (c_q.op == OP_POW) begin
					if (it_q != 6'd0) begin
						if (exp_q[0]) acc_q <= acc_q * base_q;
						base_q <= base_q * base_q;
						exp_q <= exp_q >> 1;
					end else r_q <= acc_q;
				end else begin
					if (it_q != 6'd0) begin
						if (rem_sh >= {1'b0, dvs_q}) begin
							rem_q <= 32'(rem_sh - {1'b0, dvs_q});
							quo_q <= {quo_q[30:0], 1'b1};
						end else begin
							rem_q <= rem_sh[31:0];
							quo_q <= {quo_q[30:0], 1'b0};
						end
					end else if (c_q.op == OP_DIV)
						r_q <= (na_q ^ nb_q) ? -quo_q : quo_q;
					else r_q <= na_q ? -rem_q : rem_q;
				end
			end
			default: ;
		endcase
		// new top is zero on an empty stack, else the written entry, else the unchanged top read in rdb_q
		if (st_q == ST_WB) begin
			res.top_value <= (new_cnt == '0) ? 32'd0 : wr_en ? wr_data : rdb_q;
			res.depth <= 5'(new_cnt);
			res.error <= err_q;
		end
	end

	a_one_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> !q_pop) else $error("double pop");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> st_q == ST_IDLE) else $error("done outside idle");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH)) else $error("count overflow");
endmodule
`default_nettype wire

// File: sv/stack_machine_integer_alu.sv
// stack_machine_integer_alu: top level, front queue plus back executor
// depends on smalu_pkg, smalu_front, smalu_back
`default_nettype none
// usage:
// drive cmd (op, push_value) with start; the item is a transfer at an edge
// where start is high and busy is low
// a two-entry queue holds commands while the back part works
// each command gives one result on res, marked by done for one cycle
// a command moves from the queue through the read, execute and write-back states;
// div, mod and pow add an iterate state for a 32 step shift-subtract /
// square-multiply loop, and sqrt one for a 16 step loop
// the back part works on one command at a time and takes another from the
// queue only when it is back in idle
// reset clears the stack count and queue; stack contents are left as is
// the receiver cannot stall: results appear once and must be taken
// errors leave the stack unchanged and are reported in res.error
module stack_machine_integer_alu import smalu_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire cmd_t cmd,
	output logic      busy,
	output logic      done,
	output res_t      res
);
	logic q_valid, q_pop;
	cmd_t q_cmd;

	// front: accept and queue
	smalu_front u_front (.clk, .arst_n, .start, .cmd, .busy,
		.q_valid, .q_cmd, .q_pop);

	// back: execute on stack
	smalu_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (.clk, .arst_n,
		.q_valid, .q_cmd, .q_pop, .done, .res);
endmodule
`default_nettype wire
